// ----- sv/lpcf_pkg.sv -----
// Package for the length-prefixed CRC-16 framer.
// Holds the byte kind codes, the configuration register indexes and the CRC byte update.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpcf_pkg;

    typedef enum logic [2:0] {
        KIND_MARKER  = 3'd0,
        KIND_LENGTH  = 3'd1,
        KIND_PAYLOAD = 3'd2,
        KIND_CRC_HI  = 3'd3,
        KIND_CRC_LO  = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        REG_STREAMING = 3'd0,
        REG_APPEND    = 3'd1,
        REG_POLY      = 3'd2,
        REG_SEED      = 3'd3,
        REG_MARKER_A  = 3'd4,
        REG_MARKER_B  = 3'd5
    } t_reg;

    localparam logic [15:0] POLY_RESET = 16'h1021;
    localparam logic [15:0] SEED_RESET = 16'hFFFF;

    // Output frame slots, in transmit order.
    localparam int NUM_SLOTS = 6;

    // One byte through an MSB-first CRC-16, no reflection.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc,
                                               input logic [7:0]  data,
                                               input logic [15:0] poly);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ poly;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- sv/length_prefixed_crc16_framer.sv -----
// Length-prefixed CRC-16 framer: turns a payload byte stream into transmit frame bytes.
// Uses lpcf_pkg for byte kind codes, register indexes and the CRC byte update.
//
// Usage:
//   Slave stream: tdata = {payload_length, payload_byte}, tuser = packet_start.
//   The item with packet_start set opens a packet and carries its length; with a
//   nonzero length its payload_byte is the first payload byte. Bytes outside a
//   packet are dropped. A start inside an open packet abandons it without CRC.
//   Master stream: tdata = tx_byte, tuser = {frame_end, byte_kind}, tlast = last
//   byte produced by the current input transaction.
//   Config channel: index 0..5 picks streaming_mode, append_crc, crc_polynomial,
//   crc_seed, marker_first, marker_second; always ready. Write only while idle.
// Timing:
//   An accepted item sits in a work register; its output bytes are then registered
//   one at a time in the output register. One output byte leaves per cycle while the
//   receiver is ready; an item produces up to six bytes, and mid-packet payload bytes
//   stream at one per cycle while the receiver is ready. An item that produces nothing
//   leaves the work register without output. When the receiver stalls, the output
//   register holds and the work register fills, then slave tready drops. Reset clears the
//   packet state, loads the CRC seed and resets all but the payload and output data registers.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_crc16_framer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [7:0] payload_byte, [15:8] payload_length
    input  wire logic        s_axis_tuser,   // [0] packet_start
    // master stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] tx_byte
    output logic [3:0]       m_axis_tuser,   // [2:0] byte_kind, [3] frame_end
    output logic             m_axis_tlast,   // run_last
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire lpcf_pkg::t_reg i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import lpcf_pkg::*;

    // configuration
    logic        r_streaming;
    logic        r_append;
    logic [15:0] r_poly;
    logic [15:0] r_seed;
    logic [7:0]  r_marker_a;
    logic [7:0]  r_marker_b;

    // packet state
    logic [15:0] r_crc;
    logic [7:0]  r_remaining;

    // work register
    logic        r_wv;
    logic [7:0]  r_data;
    logic [7:0]  r_len;
    logic        r_start;
    logic [2:0]  r_idx;

    // output register
    logic        r_ov;
    logic [7:0]  r_obyte;
    t_kind       r_okind;
    logic        r_olast;
    logic        r_oend;

    logic                 w_take;
    logic                 w_active;
    logic [7:0]           w_rem_after;
    logic [15:0]          w_crc_base;
    logic [15:0]          w_crc_new;
    logic [NUM_SLOTS-1:0] w_present;
    logic [2:0]           w_cnt;
    logic [2:0]           w_slot;
    logic                 w_load;
    logic                 w_emit;
    logic                 w_final;
    logic                 w_done;
    logic                 w_accept;
    logic [7:0]           w_byte;
    t_kind                w_kind;

    assign o_cfg_ready = 1'b1;

    // Per-item decode
    always_comb begin
        w_take      = r_start ? (r_len != 8'd0) : (r_remaining != 8'd0);
        w_active    = r_start || (r_remaining != 8'd0);
        w_crc_base  = r_start ? r_seed : r_crc;
        w_crc_new   = w_take ? crc16_byte(w_crc_base, r_data, r_poly) : w_crc_base;
        if (r_start) begin
            w_rem_after = w_take ? r_len - 8'd1 : 8'd0;
        end else begin
            w_rem_after = r_remaining - 8'd1;
        end
        // slot order: marker A, marker B, length, payload, CRC high, CRC low
        w_present[0] = r_start && r_streaming;
        w_present[1] = r_start && r_streaming;
        w_present[2] = r_start;
        w_present[3] = w_take;
        w_present[4] = w_active && r_append && (w_rem_after == 8'd0);
        w_present[5] = w_present[4];
    end

    // Pick the r_idx-th present slot
    always_comb begin
        w_cnt  = 3'd0;
        w_slot = 3'd0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            if (w_present[s]) begin
                if (w_cnt == r_idx) begin
                    w_slot = 3'(s);
                end
                w_cnt = w_cnt + 3'd1;
            end
        end
    end

    always_comb begin
        case (w_slot)
            3'd0: begin
                w_byte = r_marker_a;
                w_kind = KIND_MARKER;
            end
            3'd1: begin
                w_byte = r_marker_b;
                w_kind = KIND_MARKER;
            end
            3'd2: begin
                w_byte = r_append ? r_len + 8'd2 : r_len;
                w_kind = KIND_LENGTH;
            end
            3'd3: begin
                w_byte = r_data;
                w_kind = KIND_PAYLOAD;
            end
            3'd4: begin
                w_byte = w_crc_new[15:8];
                w_kind = KIND_CRC_HI;
            end
            3'd5: begin
                w_byte = w_crc_new[7:0];
                w_kind = KIND_CRC_LO;
            end
            default: begin
                w_byte = r_data;
                w_kind = KIND_PAYLOAD;
            end
        endcase
    end

    assign w_load   = !r_ov || m_axis_tready;
    assign w_emit   = r_wv && (w_cnt != 3'd0) && w_load;
    assign w_final  = (r_idx == w_cnt - 3'd1);
    assign w_done   = r_wv && ((w_cnt == 3'd0) || (w_load && w_final));
    assign w_accept = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = !r_wv || w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_streaming <= 1'b0;
            r_append    <= 1'b0;
            r_poly      <= POLY_RESET;
            r_seed      <= SEED_RESET;
            r_marker_a  <= 8'd0;
            r_marker_b  <= 8'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_STREAMING: r_streaming <= i_cfg_data[0];
                REG_APPEND:    r_append    <= i_cfg_data[0];
                REG_POLY:      r_poly      <= i_cfg_data;
                REG_SEED:      r_seed      <= i_cfg_data;
                REG_MARKER_A:  r_marker_a  <= i_cfg_data[7:0];
                REG_MARKER_B:  r_marker_b  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= SEED_RESET;
            r_remaining <= 8'd0;
            r_wv        <= 1'b0;
            r_idx       <= 3'd0;
            r_ov        <= 1'b0;
        end else begin
            if (w_done && w_active) begin
                r_crc       <= w_crc_new;
                r_remaining <= w_rem_after;
            end

            if (w_done) begin
                r_idx <= 3'd0;
            end else if (w_emit) begin
                r_idx <= r_idx + 3'd1;
            end

            if (w_accept) begin
                r_wv <= 1'b1;
            end else if (w_done) begin
                r_wv <= 1'b0;
            end

            if (w_emit) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data  <= s_axis_tdata[7:0];
            r_len   <= s_axis_tdata[15:8];
            r_start <= s_axis_tuser;
        end
        if (w_emit) begin
            r_obyte <= w_byte;
            r_okind <= w_kind;
            r_olast <= w_final;
            r_oend  <= w_final && (w_rem_after == 8'd0);
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_obyte;
    assign m_axis_tuser  = {r_oend, r_okind};
    assign m_axis_tlast  = r_olast;

endmodule

`default_nettype wire
